// File: hw/rtl/cascaded_biquad_filter_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cascaded biquad filter unit
// Concurrent checks that compile away when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef CASCADED_BIQUAD_FILTER_UNIT_ASSERT_SVH
`define CASCADED_BIQUAD_FILTER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// Check that ante implies cons in the same cycle
`define BQF_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that ante implies cons in the following cycle
`define BQF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define BQF_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define BQF_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// File: hw/rtl/bqf_pkg.sv
// ----------------------------------------------------------------------------
// bqf_pkg
// Shared widths, codes, cell interface structs and arithmetic helpers.
// ----------------------------------------------------------------------------
package bqf_pkg;

  // Data formats: samples Q23.8, coefficients Q2.29
  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 29;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int ACC_W     = PROD_W + 2;
  localparam int SLOTS     = 5;
  localparam int SLOT_W    = 3;
  localparam int SEC_W     = 2;
  localparam int CNT_W     = 3;
  localparam int LIMIT_W   = 31;
  localparam int CFG_IDX_W = 1;

  localparam int MAX_STAGES_DEF = 4;

  // Register reset values
  localparam logic [CNT_W-1:0]   SECTION_COUNT_RST  = 3'd4;
  localparam logic [LIMIT_W-1:0] OVERFLOW_LIMIT_RST = 31'd256000000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SECTION_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERFLOW_LIMIT = 1'b1;

  // Request types
  localparam logic REQ_FILTER = 1'b0;
  localparam logic REQ_COEFF  = 1'b1;

  // Coefficient slots
  localparam logic [SLOT_W-1:0] SLOT_B0 = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_B1 = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_B2 = 3'd2;
  localparam logic [SLOT_W-1:0] SLOT_A1 = 3'd3;
  localparam logic [SLOT_W-1:0] SLOT_A2 = 3'd4;

  // Controls from the sequencer to one cell
  typedef struct packed {
    logic                     start;
    logic                     clear;
    logic                     wr_en;
    logic [SLOT_W-1:0]        wr_slot;
    logic signed [DATA_W-1:0] wr_value;
  } cell_ctl_t;

  // Status from one cell back to the sequencer
  typedef struct packed {
    logic                     busy;
    logic                     done;
    logic signed [DATA_W-1:0] t;
    logic signed [DATA_W-1:0] y;
  } cell_stat_t;

  // Floor-shift an accumulator by FRAC_BITS and saturate to DATA_W bits
  function automatic logic signed [DATA_W-1:0] sat_shift(
    input logic signed [ACC_W-1:0] a
  );
    logic [ACC_W-FRAC_BITS-1:0]     q;
    logic [ACC_W-FRAC_BITS-DATA_W:0] ext;
    logic signed [DATA_W-1:0]       r;
    q   = a[ACC_W-1:FRAC_BITS];
    ext = q[ACC_W-FRAC_BITS-1:DATA_W-1];
    if ((&ext) || !(|ext)) begin
      r = q[DATA_W-1:0];
    end else if (q[ACC_W-FRAC_BITS-1]) begin
      r = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(DATA_W-1){1'b1}}};
    end
    return r;
  endfunction

  // Magnitude as unsigned; the most negative value maps to 2^31
  function automatic logic [DATA_W-1:0] mag(input logic signed [DATA_W-1:0] v);
    logic [DATA_W-1:0] r;
    if (v[DATA_W-1]) begin
      r = DATA_W'(-v);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/bqf_cell.sv
// ----------------------------------------------------------------------------
// bqf_cell
// One direct-form-I biquad section: its coefficients, its history and a
// multiplier that steps through the five products of a sample.
// ----------------------------------------------------------------------------
`include "cascaded_biquad_filter_unit_assert.svh"

module bqf_cell (
  input  logic                              clk,
  input  logic                              rst,
  input  bqf_pkg::cell_ctl_t                ctl,
  input  logic signed [bqf_pkg::DATA_W-1:0] x,
  output bqf_pkg::cell_stat_t               stat
);
  import bqf_pkg::*;

  typedef enum logic [6:0] {
    P_IDLE = 7'b0000001,
    P_B0   = 7'b0000010,
    P_B1   = 7'b0000100,
    P_B2   = 7'b0001000,
    P_A1   = 7'b0010000,
    P_A2   = 7'b0100000,
    P_Y    = 7'b1000000
  } phase_t;

  phase_t phase, phase_next;

  logic signed [DATA_W-1:0] coef [SLOTS];
  logic signed [DATA_W-1:0] x1, x2, y1, y2;
  logic signed [DATA_W-1:0] t, y;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  t_scaled;
  logic signed [DATA_W-1:0] mul_a, mul_b;
  logic                     done;

  assign prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
  assign t_scaled = {{(ACC_W-DATA_W-FRAC_BITS){t[DATA_W-1]}}, t, {FRAC_BITS{1'b0}}};

  // Pick multiplier operands for the current phase
  always_comb begin
    mul_a = coef[SLOT_B0];
    mul_b = x;
    case (phase)
      P_B1:    begin mul_a = coef[SLOT_B1]; mul_b = x1; end
      P_B2:    begin mul_a = coef[SLOT_B2]; mul_b = x2; end
      P_A1:    begin mul_a = coef[SLOT_A1]; mul_b = y1; end
      P_A2:    begin mul_a = coef[SLOT_A2]; mul_b = y2; end
      default: begin mul_a = coef[SLOT_B0]; mul_b = x;  end
    endcase
  end

  // Advance through the product sequence
  always_comb begin
    phase_next = phase;
    case (phase)
      P_IDLE:  if (ctl.start) phase_next = P_B0;
      P_B0:    phase_next = P_B1;
      P_B1:    phase_next = P_B2;
      P_B2:    phase_next = P_A1;
      P_A1:    phase_next = P_A2;
      P_A2:    phase_next = P_Y;
      P_Y:     phase_next = P_IDLE;
      default: phase_next = P_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      done  <= 1'b0;
    end else begin
      phase <= phase_next;
      done  <= (phase == P_Y);
    end
  end

  // Multiply, accumulate and round off the two halves of the section
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (phase)
      P_B1:    acc <= prod_ext;
      P_B2:    acc <= acc + prod_ext;
      P_A1:    t   <= sat_shift(acc + prod_ext);
      P_A2:    acc <= t_scaled - prod_ext;
      P_Y:     y   <= sat_shift(acc - prod_ext);
      default: acc <= acc;
    endcase
  end

  // Coefficient store: write one slot per beat
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) coef[i] <= '0;
    end else if (ctl.wr_en && (int'(ctl.wr_slot) < SLOTS)) begin
      coef[ctl.wr_slot[$clog2(SLOTS)-1:0]] <= ctl.wr_value;
    end
  end

  // History: drop on clear, shift when the section finishes
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      x1 <= '0;
      x2 <= '0;
      y1 <= '0;
      y2 <= '0;
    end else if (phase == P_Y) begin
      x1 <= x;
      x2 <= x1;
      y1 <= sat_shift(acc - prod_ext);
      y2 <= y1;
    end
  end

  assign stat.busy = (phase != P_IDLE);
  assign stat.done = done;
  assign stat.t    = t;
  assign stat.y    = y;

endmodule

// File: hw/rtl/cascaded_biquad_filter_unit.sv
// ----------------------------------------------------------------------------
// cascaded_biquad_filter_unit
// Cascade of direct-form-I biquad sections with an overflow guard.
// ----------------------------------------------------------------------------
// A sample beat runs through sections 0 .. N-1, one section at a time, where
// N is section_count clamped to 1 .. MAX_STAGES. Each section is a cell with
// its own 32x32 multiplier that steps through its five products. A guard
// check comes before each section and a peak update after it. No new
// request is taken from acceptance of a sample until its result is loaded
// into the output register. A coefficient-write beat gives no result. The
// result sits in that register, so a new sample is taken while an earlier
// result waits. After reset every coefficient and all history are zero.
// ----------------------------------------------------------------------------
`include "cascaded_biquad_filter_unit_assert.svh"

module cascaded_biquad_filter_unit #(
  parameter int MAX_STAGES = bqf_pkg::MAX_STAGES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // Request channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                req_type,
  input  logic signed [bqf_pkg::DATA_W-1:0]   sample_in,
  input  logic [bqf_pkg::SEC_W-1:0]           coeff_section,
  input  logic [bqf_pkg::SLOT_W-1:0]          coeff_slot,
  input  logic signed [bqf_pkg::DATA_W-1:0]   coeff_value,
  // Result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [bqf_pkg::DATA_W-1:0]   filtered_out,
  output logic                                history_cleared,
  // Configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bqf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bqf_pkg::DATA_W-1:0]          cfg_data
);
  import bqf_pkg::*;

  localparam int IDX_W = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
  localparam int CW    = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_GUARD = 4'b0010,
    S_RUN   = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  state_t state;

  logic [CNT_W-1:0]         section_count;
  logic [LIMIT_W-1:0]       overflow_limit;
  logic [DATA_W-1:0]        peak;
  logic [DATA_W-1:0]        peak_next;
  logic                     cleared;
  logic [IDX_W-1:0]         k;
  logic [IDX_W-1:0]         last_idx;
  logic [IDX_W-1:0]         last_idx_next;
  logic signed [DATA_W-1:0] sample;
  logic                     over;
  logic                     clr_all;
  logic                     in_fire, sample_fire, coef_fire;
  logic                     out_load;
  logic [CW-1:0]            cnt_w, max_w, last_w;
  logic [DATA_W-1:0]        mag_t, mag_y;
  logic [MAX_STAGES-1:0]    done_vec, busy_vec;

  cell_ctl_t                ctl  [MAX_STAGES];
  cell_stat_t               stat [MAX_STAGES];
  logic signed [DATA_W-1:0] x_chain [MAX_STAGES];

  assign in_ready    = (state == S_IDLE);
  assign in_fire     = in_valid && in_ready;
  assign sample_fire = in_fire && (req_type == REQ_FILTER);
  assign coef_fire   = in_fire && (req_type == REQ_COEFF);
  assign cfg_ready   = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      section_count  <= SECTION_COUNT_RST;
      overflow_limit <= OVERFLOW_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SECTION_COUNT:  section_count  <= cfg_data[CNT_W-1:0];
        CFG_OVERFLOW_LIMIT: overflow_limit <= cfg_data[LIMIT_W-1:0];
        default:            section_count  <= section_count;
      endcase
    end
  end

  // Clamp the section count to 1 .. MAX_STAGES, as a last index
  always_comb begin
    cnt_w = CW'(section_count);
    max_w = CW'(MAX_STAGES);
    if (cnt_w == '0) begin
      last_w = '0;
    end else if (cnt_w > max_w) begin
      last_w = max_w - CW'(1);
    end else begin
      last_w = cnt_w - CW'(1);
    end
    last_idx_next = last_w[IDX_W-1:0];
  end

  // Guard and peak tracking
  assign over    = (peak > {1'b0, overflow_limit});
  assign clr_all = (state == S_GUARD) && over;
  assign mag_t   = mag(stat[k].t);
  assign mag_y   = mag(stat[k].y);

  always_comb begin
    peak_next = peak;
    if (mag_t > peak_next) peak_next = mag_t;
    if (mag_y > peak_next) peak_next = mag_y;
  end

  // Sequence the sample through the cells
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      peak    <= '0;
      cleared <= 1'b0;
      k       <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (sample_fire) begin
            state   <= S_GUARD;
            k       <= '0;
            cleared <= 1'b0;
          end
        end
        S_GUARD: begin
          if (over) begin
            peak    <= '0;
            cleared <= 1'b1;
          end
          state <= S_RUN;
        end
        S_RUN: begin
          if (stat[k].done) begin
            peak <= peak_next;
            if (k == last_idx) begin
              state <= S_OUT;
            end else begin
              k     <= k + IDX_W'(1);
              state <= S_GUARD;
            end
          end
        end
        S_OUT: begin
          if (out_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Hold the sample and the active section range for the whole pass
  always_ff @(posedge clk) begin
    if (sample_fire) begin
      sample   <= sample_in;
      last_idx <= last_idx_next;
    end
  end

  // Output register
  assign out_load = (state == S_OUT) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      filtered_out    <= stat[k].y;
      history_cleared <= cleared;
    end
  end

  // Row of section cells, each but the first fed by the output of its neighbor
  for (genvar i = 0; i < MAX_STAGES; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign x_chain[i] = sample;
    end else begin : g_link
      assign x_chain[i] = stat[i-1].y;
    end

    always_comb begin
      ctl[i].start    = (state == S_GUARD) && (k == IDX_W'(i));
      ctl[i].clear    = clr_all;
      ctl[i].wr_en    = coef_fire && (int'(coeff_section) == i);
      ctl[i].wr_slot  = coeff_slot;
      ctl[i].wr_value = coeff_value;
    end

    assign done_vec[i] = stat[i].done;
    assign busy_vec[i] = stat[i].busy;

    bqf_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .ctl  (ctl[i]),
      .x    (x_chain[i]),
      .stat (stat[i])
    );
  end

  // Checks on sequencing
  `BQF_ASSERT_IMPLY(a_done_in_run, clk, rst, done_vec != '0, state == S_RUN, "done outside run")
  `BQF_ASSERT_IMPLY(a_one_busy, clk, rst, 1'b1, $onehot0(busy_vec), "two cells busy")
  `BQF_ASSERT_IMPLY(a_idle_quiet, clk, rst, state == S_IDLE, busy_vec == '0, "cell busy at idle")
  `BQF_ASSERT_NEXT(a_clear_peak, clk, rst, clr_all, peak == '0 && cleared, "peak not cleared")
  `BQF_ASSERT_IMPLY(a_k_range, clk, rst, state != S_IDLE, k <= last_idx, "section past last")

endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for cascaded_biquad_filter_unit. Drives sample and
// coefficient beats with random gaps and back-pressure, predicts every
// filtered sample in exact fixed point, and checks each result beat in order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bqf_pkg::*;

  localparam int NSEC = MAX_STAGES_DEF;
  localparam int WIDE = 2 * DATA_W + 2;
  localparam logic signed [WIDE-1:0]   WIDE_HI  = 66'sd2147483647;
  localparam logic signed [WIDE-1:0]   WIDE_LO  = -66'sd2147483648;
  localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7fffffff;
  localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh80000000;
  localparam logic signed [DATA_W-1:0] UNITY    = 32'sd536870912;
  // Feedback taps kept below 0.45 each so the section stays stable
  localparam int A_SPAN = 241591910;

  typedef struct {
    logic                     kind;
    logic signed [DATA_W-1:0] sample;
    logic [SEC_W-1:0]         section;
    logic [SLOT_W-1:0]        slot;
    logic signed [DATA_W-1:0] coeff;
  } bq_beat_t;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic                     cleared;
  } bq_result_t;

  typedef enum logic [1:0] {TAPS_STABLE, TAPS_WILD, TAPS_PASS} tap_style_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     req_type = REQ_FILTER;
  logic signed [DATA_W-1:0] sample_in = '0;
  logic [SEC_W-1:0]         coeff_section = '0;
  logic [SLOT_W-1:0]        coeff_slot = SLOT_B0;
  logic signed [DATA_W-1:0] coeff_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] filtered_out;
  logic                     history_cleared;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = CFG_SECTION_COUNT;
  logic [DATA_W-1:0]        cfg_data = '0;

  cascaded_biquad_filter_unit uut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .req_type        (req_type),
    .sample_in       (sample_in),
    .coeff_section   (coeff_section),
    .coeff_slot      (coeff_slot),
    .coeff_value     (coeff_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .filtered_out    (filtered_out),
    .history_cleared (history_cleared),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // Predicted filter state
  logic signed [DATA_W-1:0] tap_mem [NSEC*SLOTS];
  logic signed [DATA_W-1:0] x_d1 [NSEC];
  logic signed [DATA_W-1:0] x_d2 [NSEC];
  logic signed [DATA_W-1:0] y_d1 [NSEC];
  logic signed [DATA_W-1:0] y_d2 [NSEC];
  logic [DATA_W-1:0]        peak_mag;
  logic [CNT_W-1:0]         stages_cfg = SECTION_COUNT_RST;
  logic [LIMIT_W-1:0]       limit_cfg = OVERFLOW_LIMIT_RST;

  bq_beat_t   beat_q[$];
  bq_result_t expected_q[$];
  bq_beat_t   drive_beat;
  bit         beat_pending = 1'b0;
  int         send_idle_pct = 0;
  int         stall_pct = 0;
  int         mismatches = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  // Exact product of two words at accumulator width
  function automatic logic signed [WIDE-1:0] wide_mul(input logic signed [DATA_W-1:0] a,
                                                      input logic signed [DATA_W-1:0] b);
    logic signed [WIDE-1:0] aw;
    logic signed [WIDE-1:0] bw;
    aw = WIDE'(a);
    bw = WIDE'(b);
    return aw * bw;
  endfunction

  // Floor by 2^29, then clamp to one word
  function automatic logic signed [DATA_W-1:0] shift_sat(input logic signed [WIDE-1:0] acc);
    logic signed [WIDE-1:0] q;
    q = acc >>> FRAC_BITS;
    if (q > WIDE_HI) return WORD_MAX;
    if (q < WIDE_LO) return WORD_MIN;
    return q[DATA_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] abs_of(input logic signed [DATA_W-1:0] v);
    logic signed [DATA_W:0] w;
    w = (DATA_W+1)'(v);
    if (w < 0) w = -w;
    return w[DATA_W-1:0];
  endfunction

  function automatic void wipe_history();
    for (int k = 0; k < NSEC; k++) begin
      x_d1[k] = '0;
      x_d2[k] = '0;
      y_d1[k] = '0;
      y_d2[k] = '0;
    end
    peak_mag = '0;
  endfunction

  // Run one sample through the cascade and queue the expected result
  function automatic void filter_sample(input logic signed [DATA_W-1:0] smp);
    logic signed [WIDE-1:0]   acc;
    logic signed [WIDE-1:0]   tw;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] t;
    logic signed [DATA_W-1:0] y;
    int                       n;
    int                       base;
    bit                       wiped;
    bq_result_t               r;
    n = int'(stages_cfg);
    if (n == 0) n = 1;
    if (n > NSEC) n = NSEC;
    x = smp;
    wiped = 1'b0;
    for (int k = 0; k < n; k++) begin
      if (peak_mag > {1'b0, limit_cfg}) begin
        wipe_history();
        wiped = 1'b1;
      end
      base = k * SLOTS;
      acc = wide_mul(tap_mem[base + SLOT_B0], x) + wide_mul(tap_mem[base + SLOT_B1], x_d1[k])
          + wide_mul(tap_mem[base + SLOT_B2], x_d2[k]);
      t = shift_sat(acc);
      tw = WIDE'(t);
      acc = (tw <<< FRAC_BITS) - wide_mul(tap_mem[base + SLOT_A1], y_d1[k])
          - wide_mul(tap_mem[base + SLOT_A2], y_d2[k]);
      y = shift_sat(acc);
      x_d2[k] = x_d1[k];
      x_d1[k] = x;
      y_d2[k] = y_d1[k];
      y_d1[k] = y;
      if (abs_of(t) > peak_mag) peak_mag = abs_of(t);
      if (abs_of(y) > peak_mag) peak_mag = abs_of(y);
      x = y;
    end
    r.value = x;
    r.cleared = wiped;
    expected_q.push_back(r);
  endfunction

  function automatic void apply_beat(input bq_beat_t b);
    if (b.kind == REQ_COEFF) begin
      if (b.slot < SLOTS) tap_mem[b.section * SLOTS + b.slot] = b.coeff;
    end else begin
      filter_sample(b.sample);
    end
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_span(input int m);
    return int'($urandom_range(2 * m, 0)) - m;
  endfunction

  // Coefficient beat with noise on the unused sample field
  function automatic bq_beat_t coeff_beat(input int sec, input int slot,
                                          input logic signed [DATA_W-1:0] value);
    bq_beat_t b;
    b.kind = REQ_COEFF;
    b.sample = $urandom;
    b.section = SEC_W'(sec);
    b.slot = SLOT_W'(slot);
    b.coeff = value;
    return b;
  endfunction

  // Sample beat with noise on the unused coefficient fields
  function automatic bq_beat_t sample_beat(input logic signed [DATA_W-1:0] value);
    bq_beat_t b;
    b.kind = REQ_FILTER;
    b.sample = value;
    b.section = SEC_W'($urandom);
    b.slot = SLOT_W'($urandom);
    b.coeff = $urandom;
    return b;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_sample();
    case ($urandom_range(19, 0))
      0: begin
        return WORD_MAX;
      end
      1: begin
        return WORD_MIN;
      end
      2: begin
        return '0;
      end
      3, 4, 5: begin
        return $urandom;
      end
      default: begin
        return rand_span(1 << 20);
      end
    endcase
  endfunction

  // Queue a full set of five taps for one section
  function automatic void load_section(input int sec, input tap_style_t style);
    logic signed [DATA_W-1:0] tap [SLOTS];
    case (style)
      TAPS_STABLE: begin
        tap[SLOT_B0] = rand_span(1 << 28);
        tap[SLOT_B1] = rand_span(1 << 28);
        tap[SLOT_B2] = rand_span(1 << 28);
        tap[SLOT_A1] = rand_span(A_SPAN);
        tap[SLOT_A2] = rand_span(A_SPAN);
      end
      TAPS_WILD: begin
        for (int s = 0; s < SLOTS; s++) tap[s] = $urandom;
      end
      default: begin
        for (int s = 0; s < SLOTS; s++) tap[s] = '0;
        tap[SLOT_B0] = UNITY;
      end
    endcase
    for (int s = 0; s < SLOTS; s++) beat_q.push_back(coeff_beat(sec, s, tap[s]));
  endfunction

  // Tap loads followed by sample bursts, with stray writes to unused slots
  function automatic void queue_random(input int count);
    int         left;
    int         burst;
    int         pick;
    tap_style_t style;
    left = count - NSEC * SLOTS;
    for (int s = 0; s < NSEC; s++) load_section(s, TAPS_STABLE);
    while (left > 0) begin
      if ($urandom_range(3, 0) == 0) begin
        pick = $urandom_range(9, 0);
        if (pick < 6) begin
          style = TAPS_STABLE;
        end else if (pick < 8) begin
          style = TAPS_PASS;
        end else begin
          style = TAPS_WILD;
        end
        load_section($urandom_range(NSEC - 1, 0), style);
        left -= SLOTS;
      end
      if ($urandom_range(9, 0) == 0) begin
        beat_q.push_back(coeff_beat($urandom_range(NSEC - 1, 0),
                                    $urandom_range((1 << SLOT_W) - 1, SLOTS), $urandom));
        left--;
      end
      burst = $urandom_range(20, 3);
      repeat (burst) beat_q.push_back(sample_beat(pick_sample()));
      left -= burst;
    end
  endfunction

  // Edge cases at reset settings: zero taps, passthrough, extremes, saturation
  function automatic void queue_directed();
    beat_q.push_back(sample_beat(32'sd1000));
    for (int s = 0; s < NSEC; s++) beat_q.push_back(coeff_beat(s, SLOT_B0, UNITY));
    beat_q.push_back(sample_beat(WORD_MAX));
    beat_q.push_back(sample_beat(WORD_MIN));
    beat_q.push_back(sample_beat('0));
    beat_q.push_back(sample_beat(-32'sd1));
    beat_q.push_back(sample_beat(32'sd1));
    beat_q.push_back(coeff_beat(0, SLOTS, $urandom));
    beat_q.push_back(coeff_beat(NSEC - 1, (1 << SLOT_W) - 1, $urandom));
    beat_q.push_back(sample_beat(32'sd256));
    beat_q.push_back(coeff_beat(0, SLOT_B1, WORD_MIN));
    beat_q.push_back(coeff_beat(1, SLOT_A1, WORD_MAX));
    beat_q.push_back(coeff_beat(2, SLOT_B2, -(UNITY >>> 1)));
    beat_q.push_back(coeff_beat(3, SLOT_A2, UNITY >>> 2));
    beat_q.push_back(sample_beat(32'sd12345));
    beat_q.push_back(sample_beat(WORD_MAX));
    beat_q.push_back(sample_beat(WORD_MIN));
    beat_q.push_back(sample_beat(-32'sd77));
    beat_q.push_back(sample_beat('0));
    beat_q.push_back(coeff_beat(0, SLOT_B0, WORD_MAX));
    beat_q.push_back(sample_beat(WORD_MAX));
    beat_q.push_back(sample_beat(WORD_MIN));
  endfunction

  task automatic flag(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  // Hold until every beat is sent and every result is back, then let the
  // pipeline empty out
  task automatic settle();
    while (beat_q.size() > 0 || beat_pending || expected_q.size() > 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_SECTION_COUNT) begin
      stages_cfg = data[CNT_W-1:0];
    end else begin
      limit_cfg = data[LIMIT_W-1:0];
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drain, then write both registers with noise in the unused bits and set the gap and stall percentages
  task automatic retune(input int cnt, input logic [LIMIT_W-1:0] lim,
                        input int sidle, input int stall);
    logic [DATA_W-1:0] d;
    settle();
    d = $urandom;
    d[CNT_W-1:0] = CNT_W'(cnt);
    write_reg(CFG_SECTION_COUNT, d);
    d = $urandom;
    d[LIMIT_W-1:0] = lim;
    write_reg(CFG_OVERFLOW_LIMIT, d);
    send_idle_pct = sidle;
    stall_pct = stall;
  endtask

  // Drive request beats at the falling edge, holding each until accepted
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!beat_pending) begin
      if (beat_q.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        drive_beat = beat_q.pop_front();
        beat_pending = 1'b1;
        in_valid <= 1'b1;
        req_type <= drive_beat.kind;
        sample_in <= drive_beat.sample;
        coeff_section <= drive_beat.section;
        coeff_slot <= drive_beat.slot;
        coeff_value <= drive_beat.coeff;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Advance the prediction on each accepted request beat
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      apply_beat(drive_beat);
      beat_pending = 1'b0;
    end
  end

  // Random back-pressure on the result channel
  always @(negedge clk) begin
    out_ready <= !rst && ($urandom_range(99, 0) >= stall_pct);
  end

  // Compare each result beat with the oldest prediction
  always @(posedge clk) begin
    bq_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        flag($sformatf("%0t: result beat with nothing pending: out=%0d cleared=%0b",
                       $realtime, filtered_out, history_cleared));
      end else begin
        want = expected_q.pop_front();
        if (filtered_out !== want.value)
          flag($sformatf("%0t: filtered_out expected %0d got %0d",
                         $realtime, want.value, filtered_out));
        if (history_cleared !== want.cleared)
          flag($sformatf("%0t: history_cleared expected %0b got %0b",
                         $realtime, want.cleared, history_cleared));
      end
    end
  end

  initial begin
    for (int i = 0; i < NSEC * SLOTS; i++) tap_mem[i] = '0;
    wipe_history();
    send_idle_pct = 12;
    stall_pct = 57;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    queue_directed();
    queue_random(230);

    // One section, highest limit: only the most negative magnitude trips it
    retune(1, '1, 12, 57);
    beat_q.push_back(coeff_beat(0, SLOT_B0, UNITY));
    for (int s = int'(SLOT_B1); s < SLOTS; s++) beat_q.push_back(coeff_beat(0, s, '0));
    beat_q.push_back(sample_beat(WORD_MAX));
    beat_q.push_back(sample_beat(WORD_MIN));
    beat_q.push_back(sample_beat(32'sd5));
    queue_random(230);

    retune(0, '0, 57, 12);
    queue_random(230);
    retune((1 << CNT_W) - 1, 31'd256000, 57, 12);
    queue_random(230);
    retune(2, OVERFLOW_LIMIT_RST, 0, 0);
    queue_random(230);
    retune(3, LIMIT_W'($urandom_range(1 << 28, 1 << 12)), 0, 0);
    queue_random(230);
    retune(NSEC + 2, LIMIT_W'($urandom), 0, 0);
    queue_random(230);

    settle();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: cascaded_biquad_filter_unit.f
+incdir+hw/rtl
hw/rtl/bqf_pkg.sv
hw/rtl/bqf_cell.sv
hw/rtl/cascaded_biquad_filter_unit.sv
dv/tb.sv
